@@ hw/rtl/m3inv_pkg.sv @@
// m3inv_pkg: shared constants for the 3x3 matrix inverse
// default element format and the cofactor index table (column-major, k = row + 3*col)
// no dependencies
`default_nettype none

package m3inv_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int NUM_ELEM       = 9;
    localparam int NUM_ROW        = 3;

    // adjugate entry k = m[p]*m[q] - m[r]*m[s], given as {p, q, r, s}
    localparam int COF_IDX [NUM_ELEM][4] = '{
        '{4, 8, 5, 7},
        '{2, 7, 1, 8},
        '{1, 5, 2, 4},
        '{5, 6, 3, 8},
        '{0, 8, 2, 6},
        '{2, 3, 0, 5},
        '{3, 7, 4, 6},
        '{1, 6, 0, 7},
        '{0, 4, 1, 3}
    };

endpackage

`default_nettype wire

@@ hw/rtl/matrix3_inverse.sv @@
// matrix3_inverse: one matrix per cycle while inv_stall is low
// products, cofactors, determinant in five stages, then one stage for magnitudes, one for
// overflow detect, one restoring quotient bit per stage in nine parallel divider lanes,
// then saturation
// each stage moves when empty or when the next one moves, so bubbles collapse under stall
// reset clears the stage valid bits only; data registers are not reset
// depends on m3inv_pkg
`default_nettype none

module matrix3_inverse
    import m3inv_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         mat_valid,
    output logic                              mat_stall,
    input  wire logic signed [DATA_WIDTH-1:0] r0c0,
    input  wire logic signed [DATA_WIDTH-1:0] r1c0,
    input  wire logic signed [DATA_WIDTH-1:0] r2c0,
    input  wire logic signed [DATA_WIDTH-1:0] r0c1,
    input  wire logic signed [DATA_WIDTH-1:0] r1c1,
    input  wire logic signed [DATA_WIDTH-1:0] r2c1,
    input  wire logic signed [DATA_WIDTH-1:0] r0c2,
    input  wire logic signed [DATA_WIDTH-1:0] r1c2,
    input  wire logic signed [DATA_WIDTH-1:0] r2c2,

    output logic                              inv_valid,
    input  wire logic                         inv_stall,
    output logic signed [DATA_WIDTH-1:0]      inv_r0c0,
    output logic signed [DATA_WIDTH-1:0]      inv_r1c0,
    output logic signed [DATA_WIDTH-1:0]      inv_r2c0,
    output logic signed [DATA_WIDTH-1:0]      inv_r0c1,
    output logic signed [DATA_WIDTH-1:0]      inv_r1c1,
    output logic signed [DATA_WIDTH-1:0]      inv_r2c1,
    output logic signed [DATA_WIDTH-1:0]      inv_r0c2,
    output logic signed [DATA_WIDTH-1:0]      inv_r1c2,
    output logic signed [DATA_WIDTH-1:0]      inv_r2c2,
    output logic                              singular,
    output logic                              saturated
);

    localparam int W    = DATA_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int PW   = 2 * W;
    localparam int AW   = 2 * W + 1;
    localparam int HW   = 2 * W + 1;
    localparam int DTW  = 3 * W + 2;
    localparam int NWA  = 2 * W + 2 * F;
    localparam int NWB  = 3 * W + 1;
    localparam int NW   = ((NWA > NWB) ? NWA : NWB) + 1;
    localparam int CW   = NW + W;
    localparam int DIV0 = 6;
    localparam int NST  = W + 8;

    // handshake and stage valids
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] en;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || !inv_stall;
        for (int s = NST - 2; s >= 0; s--)
        begin
            en[s] = !vld_reg[s] || en[s+1];
        end
        vld_next[0] = mat_valid;
        for (int s = 1; s < NST; s++)
        begin
            vld_next[s] = vld_reg[s-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int s = 0; s < NST; s++)
            begin
                if (en[s])
                begin
                    vld_reg[s] <= vld_next[s];
                end
            end
        end
    end

    assign mat_stall = !en[0];
    assign inv_valid = vld_reg[NST-1];

    logic signed [W-1:0] elem [NUM_ELEM];

    assign elem[0] = r0c0;
    assign elem[1] = r1c0;
    assign elem[2] = r2c0;
    assign elem[3] = r0c1;
    assign elem[4] = r1c1;
    assign elem[5] = r2c1;
    assign elem[6] = r0c2;
    assign elem[7] = r1c2;
    assign elem[8] = r2c2;

    // front end: products, cofactors, determinant
    logic signed [PW-1:0]  prod_a_reg [NUM_ELEM];
    logic signed [PW-1:0]  prod_b_reg [NUM_ELEM];
    logic signed [W-1:0]   mrow0_reg  [NUM_ROW];
    logic signed [W-1:0]   mrow1_reg  [NUM_ROW];
    logic        [AW-1:0]  adj1_reg   [NUM_ELEM];
    logic        [AW-1:0]  adj2_reg   [NUM_ELEM];
    logic        [AW-1:0]  adj3_reg   [NUM_ELEM];
    logic        [AW-1:0]  adj4_reg   [NUM_ELEM];
    logic signed [HW-1:0]  plo_reg    [NUM_ROW];
    logic signed [HW-1:0]  phi_reg    [NUM_ROW];
    logic        [DTW-1:0] term_reg   [NUM_ROW];
    logic        [DTW-1:0] det4_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < NUM_ELEM; k++)
            begin
                prod_a_reg[k] <= elem[COF_IDX[k][0]] * elem[COF_IDX[k][1]];
                prod_b_reg[k] <= elem[COF_IDX[k][2]] * elem[COF_IDX[k][3]];
            end
            for (int i = 0; i < NUM_ROW; i++)
            begin
                mrow0_reg[i] <= elem[i];
            end
        end
        if (en[1])
        begin
            for (int k = 0; k < NUM_ELEM; k++)
            begin
                adj1_reg[k] <= {prod_a_reg[k][PW-1], prod_a_reg[k]}
                             - {prod_b_reg[k][PW-1], prod_b_reg[k]};
            end
            for (int i = 0; i < NUM_ROW; i++)
            begin
                mrow1_reg[i] <= mrow0_reg[i];
            end
        end
        if (en[2])
        begin
            // split each first-row term into two narrow partial products
            for (int i = 0; i < NUM_ROW; i++)
            begin
                plo_reg[i] <= mrow1_reg[i] * $signed({1'b0, adj1_reg[3*i][W-1:0]});
                phi_reg[i] <= mrow1_reg[i] * $signed(adj1_reg[3*i][AW-1:W]);
            end
            adj2_reg <= adj1_reg;
        end
        if (en[3])
        begin
            for (int i = 0; i < NUM_ROW; i++)
            begin
                term_reg[i] <= {phi_reg[i][HW-1], phi_reg[i], {W{1'b0}}}
                             + {{(W+1){plo_reg[i][HW-1]}}, plo_reg[i]};
            end
            adj3_reg <= adj2_reg;
        end
        if (en[4])
        begin
            det4_reg <= term_reg[0] + term_reg[1] + term_reg[2];
            adj4_reg <= adj3_reg;
        end
    end

    // magnitudes and rounded dividend: num = |A| * 2^(2F+1) + |D|, den = 2|D|
    logic [DTW-1:0] dmag;
    logic [AW-1:0]  amag [NUM_ELEM];
    logic [NW-1:0]  num5 [NUM_ELEM];
    logic [NW-1:0]  den5;

    always_comb
    begin
        dmag = det4_reg[DTW-1] ? (~det4_reg + 1'b1) : det4_reg;
        den5 = NW'(dmag) << 1;
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            amag[k] = adj4_reg[k][AW-1] ? (~adj4_reg[k] + 1'b1) : adj4_reg[k];
            num5[k] = (NW'(amag[k]) << (2 * F + 1)) + NW'(dmag);
        end
    end

    logic [NW-1:0] num5_reg [NUM_ELEM];
    logic [NW-1:0] den5_reg;
    logic          neg5_reg [NUM_ELEM];
    logic          zero5_reg;

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            for (int k = 0; k < NUM_ELEM; k++)
            begin
                num5_reg[k] <= num5[k];
                neg5_reg[k] <= adj4_reg[k][AW-1] ^ det4_reg[DTW-1];
            end
            den5_reg  <= den5;
            zero5_reg <= (det4_reg == '0);
        end
    end

    // divider lanes: index 0 holds the overflow check, index i the first i quotient bits
    logic [NW-1:0] rem_reg  [W+1][NUM_ELEM];
    logic [W-1:0]  q_reg    [W+1][NUM_ELEM];
    logic          ovf_reg  [W+1][NUM_ELEM];
    logic          neg_reg  [W+1][NUM_ELEM];
    logic [NW-1:0] den_reg  [W+1];
    logic          zero_reg [W+1];

    always_ff @(posedge clk)
    begin
        if (en[DIV0])
        begin
            for (int k = 0; k < NUM_ELEM; k++)
            begin
                rem_reg[0][k] <= num5_reg[k];
                q_reg[0][k]   <= '0;
                ovf_reg[0][k] <= CW'(num5_reg[k]) >= (CW'(den5_reg) << W);
                neg_reg[0][k] <= neg5_reg[k];
            end
            den_reg[0]  <= den5_reg;
            zero_reg[0] <= zero5_reg;
        end
    end

    for (genvar i = 1; i <= W; i++)
    begin : g_step
        logic [CW-1:0] dsh;
        logic [CW-1:0] diff [NUM_ELEM];
        logic          ge   [NUM_ELEM];

        always_comb
        begin
            dsh = CW'(den_reg[i-1]) << (W - i);
            for (int k = 0; k < NUM_ELEM; k++)
            begin
                ge[k]   = CW'(rem_reg[i-1][k]) >= dsh;
                diff[k] = CW'(rem_reg[i-1][k]) - dsh;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[DIV0+i])
            begin
                for (int k = 0; k < NUM_ELEM; k++)
                begin
                    rem_reg[i][k] <= ge[k] ? diff[k][NW-1:0] : rem_reg[i-1][k];
                    q_reg[i][k]   <= {q_reg[i-1][k][W-2:0], ge[k]};
                    ovf_reg[i][k] <= ovf_reg[i-1][k];
                    neg_reg[i][k] <= neg_reg[i-1][k];
                end
                den_reg[i]  <= den_reg[i-1];
                zero_reg[i] <= zero_reg[i-1];
            end
        end
    end

    // saturation and sign
    logic [W-1:0] limit [NUM_ELEM];
    logic         clip  [NUM_ELEM];
    logic [W-1:0] mag   [NUM_ELEM];
    logic [W-1:0] res   [NUM_ELEM];
    logic         any_clip;

    always_comb
    begin
        any_clip = 1'b0;
        for (int k = 0; k < NUM_ELEM; k++)
        begin
            limit[k] = {1'b0, {(W-1){1'b1}}} + W'(neg_reg[W][k]);
            clip[k]  = ovf_reg[W][k] || (q_reg[W][k] > limit[k]);
            mag[k]   = clip[k] ? limit[k] : q_reg[W][k];
            res[k]   = neg_reg[W][k] ? (~mag[k] + 1'b1) : mag[k];
            any_clip = any_clip | clip[k];
        end
    end

    logic [W-1:0] inv_reg [NUM_ELEM];
    logic         singular_reg;
    logic         saturated_reg;

    always_ff @(posedge clk)
    begin
        if (en[NST-1])
        begin
            for (int k = 0; k < NUM_ELEM; k++)
            begin
                inv_reg[k] <= zero_reg[W] ? '0 : res[k];
            end
            singular_reg  <= zero_reg[W];
            saturated_reg <= !zero_reg[W] && any_clip;
        end
    end

    assign inv_r0c0  = inv_reg[0];
    assign inv_r1c0  = inv_reg[1];
    assign inv_r2c0  = inv_reg[2];
    assign inv_r0c1  = inv_reg[3];
    assign inv_r1c1  = inv_reg[4];
    assign inv_r2c1  = inv_reg[5];
    assign inv_r0c2  = inv_reg[6];
    assign inv_r1c2  = inv_reg[7];
    assign inv_r2c2  = inv_reg[8];
    assign singular  = singular_reg;
    assign saturated = saturated_reg;

endmodule

`default_nettype wire
